// ===== sv/mono_framebuffer_line_draw_top_macros.svh =====
// assertion helpers for the line draw engine
`ifndef MONO_FRAMEBUFFER_LINE_DRAW_TOP_MACROS_SVH
`define MONO_FRAMEBUFFER_LINE_DRAW_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// clocked check, disabled while reset is asserted
`define MFLD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define MFLD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MFLD_ASSERT(lbl, clk, rst_n, prop, msg)
`define MFLD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== sv/mfld_pkg.sv =====
package mfld_pkg;

    // panel geometry
    localparam int PANEL_WIDTH  = 200;
    localparam int PANEL_HEIGHT = 200;
    localparam int LINE_BYTES   = (PANEL_WIDTH + 7) / 8;
    localparam int STORE_BYTES  = LINE_BYTES * PANEL_HEIGHT;
    localparam int MAX_DIM      = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;

    // widths
    localparam int ADDR_W  = $clog2(STORE_BYTES);
    localparam int COORD_W = $clog2(MAX_DIM);
    localparam int CALC_W  = 18;
    localparam int CMD_W   = 2;
    localparam int IN_W    = 16;
    localparam int BI_W    = 13;
    localparam int DATA_W  = 8;
    localparam int ROT_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PIXEL = 2'd0,
        CMD_HLINE = 2'd1,
        CMD_VLINE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
    localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
    localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
    localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

    // one clipped and mapped run handed to the store engine
    typedef struct packed {
        logic               draw_ok;
        logic               is_read;
        logic               raw_horiz;
        logic [COORD_W-1:0] fix;
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi;
        logic               color;
        logic [BI_W-1:0]    byte_index;
    } span_cmd_t;

    typedef struct packed {
        logic idle;
        logic rd_valid;
    } eng_status_t;

endpackage

// ===== sv/mfld_span.sv =====
module mfld_span
    import mfld_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    input  logic [CMD_W-1:0]        in_cmd,
    input  logic signed [IN_W-1:0]  in_x,
    input  logic signed [IN_W-1:0]  in_y,
    input  logic signed [IN_W-1:0]  in_len,
    input  logic                    in_color,
    input  logic [BI_W-1:0]         in_byte_index,
    input  logic [ROT_W-1:0]        rotation,
    output logic                    out_valid,
    output span_cmd_t               out_span,
    output logic                    busy
);

    logic      s1_valid_reg, s1_valid_next;
    logic      s2_valid_reg, s2_valid_next;
    span_cmd_t s1_reg, s1_next;
    span_cmd_t s2_reg, s2_next;

    // stage 1: clip to the logical canvas
    always_comb begin
        logic signed [CALC_W-1:0] start_w, len_w, fix_w, lim_w, limf_w;
        logic signed [CALC_W-1:0] lw, lh, a_w, b_w, lo_w, hi_w;
        logic                     horiz;
        horiz   = (in_cmd != CMD_VLINE);
        lw      = rotation[0] ? CALC_W'(PANEL_HEIGHT) : CALC_W'(PANEL_WIDTH);
        lh      = rotation[0] ? CALC_W'(PANEL_WIDTH) : CALC_W'(PANEL_HEIGHT);
        start_w = horiz ? CALC_W'(in_x) : CALC_W'(in_y);
        fix_w   = horiz ? CALC_W'(in_y) : CALC_W'(in_x);
        len_w   = (in_cmd == CMD_PIXEL) ? CALC_W'(1) : CALC_W'(in_len);
        lim_w   = horiz ? lw : lh;
        limf_w  = horiz ? lh : lw;
        if (len_w < 0) begin
            a_w = start_w + len_w + CALC_W'(1);
            b_w = start_w;
        end else begin
            a_w = start_w;
            b_w = start_w + len_w - CALC_W'(1);
        end
        lo_w = (a_w < 0) ? CALC_W'(0) : a_w;
        hi_w = (b_w > lim_w - CALC_W'(1)) ? lim_w - CALC_W'(1) : b_w;

        s1_next.draw_ok    = (in_cmd != CMD_READ) && (len_w != 0) && (fix_w >= 0)
                             && (fix_w < limf_w) && (lo_w <= hi_w);
        s1_next.is_read    = (in_cmd == CMD_READ);
        s1_next.raw_horiz  = horiz;  // logical direction at this stage
        s1_next.fix        = fix_w[COORD_W-1:0];
        s1_next.lo         = lo_w[COORD_W-1:0];
        s1_next.hi         = hi_w[COORD_W-1:0];
        s1_next.color      = in_color;
        s1_next.byte_index = in_byte_index;
    end

    // stage 2: turn the logical run into a raw row or column run
    always_comb begin
        logic               horiz, flip_span, flip_fix;
        logic [COORD_W-1:0] span_max, fix_max;
        horiz     = s1_reg.raw_horiz;
        flip_span = (rotation == ROT_180) || (horiz ? (rotation == ROT_270)
                                                    : (rotation == ROT_90));
        flip_fix  = (rotation == ROT_180) || (horiz ? (rotation == ROT_90)
                                                    : (rotation == ROT_270));
        s2_next           = s1_reg;
        s2_next.raw_horiz = horiz ^ rotation[0];
        span_max = s2_next.raw_horiz ? COORD_W'(PANEL_WIDTH - 1) : COORD_W'(PANEL_HEIGHT - 1);
        fix_max  = s2_next.raw_horiz ? COORD_W'(PANEL_HEIGHT - 1) : COORD_W'(PANEL_WIDTH - 1);
        s2_next.lo  = flip_span ? span_max - s1_reg.hi : s1_reg.lo;
        s2_next.hi  = flip_span ? span_max - s1_reg.lo : s1_reg.hi;
        s2_next.fix = flip_fix ? fix_max - s1_reg.fix : s1_reg.fix;
    end

    assign s1_valid_next = in_valid;
    assign s2_valid_next = s1_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            s1_reg <= s1_next;
        end
        if (s1_valid_reg) begin
            s2_reg <= s2_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_span  = s2_reg;
    assign busy      = s1_valid_reg | s2_valid_reg;

endmodule

// ===== sv/mfld_store.sv =====
`include "mono_framebuffer_line_draw_top_macros.svh"

module mfld_store
    import mfld_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start_valid,
    input  span_cmd_t         start,
    input  logic              out_free,
    output eng_status_t       status,
    output logic [DATA_W-1:0] rd_byte
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_READ  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [COORD_W-1:0] cnt_reg, cnt_next;
    logic               horiz_reg, horiz_next;
    logic               first_reg, first_next;
    logic [DATA_W-1:0]  first_mask_reg, first_mask_next;
    logic [DATA_W-1:0]  last_mask_reg, last_mask_next;
    logic               color_reg, color_next;
    logic               rd_zero_reg, rd_zero_next;
    logic               wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0]  wr_addr_reg, wr_addr_next;
    logic [DATA_W-1:0]  wr_mask_reg, wr_mask_next;
    logic               rd_pend_reg, rd_pend_next;
    logic [DATA_W-1:0]  rd_q_reg;

    logic [DATA_W-1:0]  mem [STORE_BYTES];

    logic               rd_en;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [DATA_W-1:0]  wr_data;
    logic [DATA_W-1:0]  run_mask;

    // byte mask for the current access of a run
    always_comb begin
        if (horiz_reg) begin
            run_mask = (first_reg ? first_mask_reg : 8'hFF)
                     & ((cnt_reg == '0) ? last_mask_reg : 8'hFF);
        end else begin
            run_mask = first_mask_reg;
        end
    end

    always_comb begin
        logic [COORD_W-1:0] row_sel, col_sel;
        state_next      = state_reg;
        addr_next       = addr_reg;
        cnt_next        = cnt_reg;
        horiz_next      = horiz_reg;
        first_next      = first_reg;
        first_mask_next = first_mask_reg;
        last_mask_next  = last_mask_reg;
        color_next      = color_reg;
        rd_zero_next    = rd_zero_reg;
        wr_pend_next    = 1'b0;
        wr_addr_next    = wr_addr_reg;
        wr_mask_next    = wr_mask_reg;
        rd_pend_next    = 1'b0;
        rd_en           = 1'b0;
        row_sel         = start.raw_horiz ? start.fix : start.lo;
        col_sel         = start.raw_horiz ? start.lo : start.fix;
        case (state_reg)
            ST_CLEAR: begin
                addr_next = addr_reg + ADDR_W'(1);
                if (addr_reg == ADDR_W'(STORE_BYTES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start_valid && start.is_read) begin
                    state_next   = ST_READ;
                    addr_next    = ADDR_W'(start.byte_index);
                    rd_zero_next = (32'(start.byte_index) >= 32'(STORE_BYTES));
                end else if (start_valid && start.draw_ok) begin
                    state_next  = ST_RUN;
                    addr_next   = ADDR_W'(row_sel) * ADDR_W'(LINE_BYTES)
                                + ADDR_W'(col_sel[COORD_W-1:3]);
                    horiz_next  = start.raw_horiz;
                    first_next  = 1'b1;
                    color_next  = start.color;
                    cnt_next    = start.raw_horiz
                                ? (start.hi >> 3) - (start.lo >> 3)
                                : start.hi - start.lo;
                    first_mask_next = start.raw_horiz ? (8'hFF >> start.lo[2:0])
                                                      : (8'h80 >> start.fix[2:0]);
                    last_mask_next  = ~(8'h7F >> start.hi[2:0]);
                end
            end
            ST_RUN: begin
                rd_en        = 1'b1;
                wr_pend_next = 1'b1;
                wr_addr_next = addr_reg;
                wr_mask_next = run_mask;
                first_next   = 1'b0;
                addr_next    = addr_reg + (horiz_reg ? ADDR_W'(1) : ADDR_W'(LINE_BYTES));
                cnt_next     = cnt_reg - COORD_W'(1);
                if (cnt_reg == '0) begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                if (out_free) begin
                    rd_en        = 1'b1;
                    rd_pend_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // write side: clearing sweep or the modified byte of the previous read
    always_comb begin
        wr_en   = (state_reg == ST_CLEAR) | wr_pend_reg;
        wr_addr = (state_reg == ST_CLEAR) ? addr_reg : wr_addr_reg;
        if (state_reg == ST_CLEAR) begin
            wr_data = '0;
        end else if (color_reg) begin
            wr_data = rd_q_reg | wr_mask_reg;
        end else begin
            wr_data = rd_q_reg & ~wr_mask_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            addr_reg    <= '0;
            wr_pend_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            wr_pend_reg <= wr_pend_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg        <= cnt_next;
        horiz_reg      <= horiz_next;
        first_reg      <= first_next;
        first_mask_reg <= first_mask_next;
        last_mask_reg  <= last_mask_next;
        color_reg      <= color_next;
        rd_zero_reg    <= rd_zero_next;
        wr_addr_reg    <= wr_addr_next;
        wr_mask_reg    <= wr_mask_next;
    end

    assign status.idle     = (state_reg == ST_IDLE) & ~wr_pend_reg & ~rd_pend_reg;
    assign status.rd_valid = rd_pend_reg;
    assign rd_byte         = rd_zero_reg ? '0 : rd_q_reg;

    // a new run never starts on top of an unfinished write or read
    `MFLD_ASSERT(a_start_when_idle, aclk, aresetn, start_valid |-> (state_reg == ST_IDLE && !wr_pend_reg && !rd_pend_reg), "engine started while busy")
    // read and write of a run never hit the same byte in one cycle
    `MFLD_ASSERT(a_no_rmw_overlap, aclk, aresetn, (state_reg == ST_RUN && wr_pend_reg) |-> (wr_addr_reg != addr_reg), "read-modify-write overlap")
    // a read result follows a read issue in the cycle before
    `MFLD_ASSERT(a_rd_after_issue, aclk, aresetn, rd_pend_reg |-> $past(state_reg == ST_READ && out_free), "read result without issue")

endmodule

// ===== sv/mono_framebuffer_line_draw_top.sv =====
// a read item's byte passes the span stages, the engine read state and the memory read
//   register to the output register, later if it holds an earlier byte; draws give no result
// the input stays closed until an item has left both span stages and the engine is idle; the
//   engine reads and rewrites each byte a drawing item touches (a pixel one, a row run up to 25,
//   a column run up to 200); on reset, aresetn low clears rotation and control, then a clearing
//   pass zeroes all 5000 bytes of the store, with s_ready low and configuration writes still taken
`include "mono_framebuffer_line_draw_top_macros.svh"

module mono_framebuffer_line_draw_top
    import mfld_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // item input
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [CMD_W-1:0]        s_cmd,
    input  logic signed [IN_W-1:0]  s_x_coord,
    input  logic signed [IN_W-1:0]  s_y_coord,
    input  logic signed [IN_W-1:0]  s_length,
    input  logic                    s_color,
    input  logic [BI_W-1:0]         s_byte_index,
    // read result output
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [DATA_W-1:0]       m_read_data,
    // rotation register write
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [ROT_W-1:0]        cfg_data
);

    logic [ROT_W-1:0]  rotation_reg, rotation_next;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_data_reg, m_data_next;

    logic              s_accept;
    logic              span_valid;
    span_cmd_t         span_cmd;
    logic              span_busy;
    eng_status_t       eng_status;
    logic [DATA_W-1:0] eng_rd_byte;
    logic              out_free;

    // one item in flight at a time: the two span stages plus the store engine
    assign s_ready   = ~span_busy & eng_status.idle;
    assign s_accept  = s_valid & s_ready;
    assign cfg_ready = 1'b1;

    // output slot is free next cycle if empty now or being taken now
    assign out_free = ~m_valid_reg | m_ready;

    // clip and map: two register stages
    mfld_span u_span (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_accept),
        .in_cmd        (s_cmd),
        .in_x          (s_x_coord),
        .in_y          (s_y_coord),
        .in_len        (s_length),
        .in_color      (s_color),
        .in_byte_index (s_byte_index),
        .rotation      (rotation_reg),
        .out_valid     (span_valid),
        .out_span      (span_cmd),
        .busy          (span_busy)
    );

    // framebuffer memory with its read-modify-write sequencer
    mfld_store u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start_valid (span_valid),
        .start       (span_cmd),
        .out_free    (out_free),
        .status      (eng_status),
        .rd_byte     (eng_rd_byte)
    );

    // rotation register
    always_comb begin
        rotation_next = rotation_reg;
        if (cfg_valid && cfg_ready) begin
            rotation_next = cfg_data;
        end
    end

    // output register, loaded by a finished read
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (eng_status.rd_valid) begin
            m_valid_next = 1'b1;
            m_data_next  = eng_rd_byte;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rotation_reg <= ROT_0;
            m_valid_reg  <= 1'b0;
        end else begin
            rotation_reg <= rotation_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_data_reg;

    // a read result only lands in an empty output slot
    `MFLD_ASSERT(a_out_slot_free, aclk, aresetn, eng_status.rd_valid |-> !m_valid_reg, "read result overwrites pending item")
    // the span stage hands over only to an idle engine
    `MFLD_ASSERT(a_handover_idle, aclk, aresetn, span_valid |-> eng_status.idle, "span handed to busy engine")
    // an accepted item blocks the input on the next cycle
    `MFLD_ASSERT(a_busy_after_accept, aclk, aresetn, s_accept |=> !s_ready, "input open while item in flight")

endmodule
